/* rtl/core/seg_mask_dot_upsample_core_assert.svh */
// Assertion macros for the mask dot product core.
// Used by the top level only; define ASSERT_OFF to drop them.
`ifndef SEG_MASK_DOT_UPSAMPLE_CORE_ASSERT_SVH
`define SEG_MASK_DOT_UPSAMPLE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SMDU_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("smdu assertion failed");
`define SMDU_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("smdu assertion failed");
`else
`define SMDU_ASSERT_IMP(label, clk, rst_n, a, b)
`define SMDU_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

/* rtl/core/smdu_pkg.sv */
// Shared constants, codes and types of the mask dot product core.
// No dependencies.
package smdu_pkg;
    localparam int PROTO_MAX_W = 64;
    localparam int PROTO_MAX_H = 64;
    localparam int NUM_COEFF   = 32;
    localparam int PROTO_DEPTH = PROTO_MAX_W * PROTO_MAX_H * NUM_COEFF;
    localparam int PA_W        = 17;
    localparam int CI_W        = 5;
    localparam int VAL_W       = 16;
    localparam int BOX_W       = 12;
    localparam int CRD_W       = 6;
    localparam int SIZE_W      = 7;
    localparam int CELL_W      = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;
    localparam int ACC_W       = 37;

    localparam logic [1:0] ACT_PROTO = 2'd0;
    localparam logic [1:0] ACT_COEFF = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PROTO_W  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTO_H  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_L    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_T    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_X  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_Y  = 3'd7;

    typedef enum logic [1:0] {OP_PROTO, OP_COEFF, OP_QUERY} t_op;

    typedef struct packed {
        t_op                     op;
        logic [PA_W-1:0]         addr;
        logic signed [VAL_W-1:0] value;
        logic [CI_W-1:0]         cidx;
        logic [BOX_W-1:0]        bl;
        logic [BOX_W-1:0]        bu;
        logic [BOX_W-1:0]        br;
        logic [BOX_W-1:0]        bd;
        logic [BOX_W-1:0]        oc;
        logic [BOX_W-1:0]        orow;
    } t_item;

    typedef struct packed {
        logic [SIZE_W-1:0] pw;
        logic [SIZE_W-1:0] ph;
        logic [19:0]       scale_x;
        logic [19:0]       scale_y;
        logic [9:0]        pad_l;
        logic [9:0]        pad_t;
        logic [16:0]       ratio_x;
        logic [16:0]       ratio_y;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;
endpackage

/* rtl/core/smdu_front.sv */
// Front end: accepts input beats, decodes the action and pushes work items.
// Depends on smdu_pkg.
module smdu_front (
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_action,
    input  logic [smdu_pkg::PA_W-1:0]    i_proto_addr,
    input  logic signed [15:0]           i_proto_value,
    input  logic [smdu_pkg::CI_W-1:0]    i_coeff_index,
    input  logic signed [15:0]           i_coeff_value,
    input  logic [11:0]                  i_box_left,
    input  logic [11:0]                  i_box_upper,
    input  logic [11:0]                  i_box_right,
    input  logic [11:0]                  i_box_lower,
    input  logic [11:0]                  i_out_col,
    input  logic [11:0]                  i_out_row,
    input  smdu_pkg::t_qstat             i_qstat,
    output logic                         o_push,
    output smdu_pkg::t_item              o_item
);
    import smdu_pkg::*;

    logic w_known;

    always_comb begin
        w_known      = 1'b1;
        o_item.op    = OP_QUERY;
        o_item.value = i_proto_value;
        case (i_action)
            ACT_PROTO: o_item.op = OP_PROTO;
            ACT_COEFF: begin
                o_item.op    = OP_COEFF;
                o_item.value = i_coeff_value;
            end
            ACT_QUERY: o_item.op = OP_QUERY;
            default:   w_known = 1'b0;
        endcase
        o_item.addr = i_proto_addr;
        o_item.cidx = i_coeff_index;
        o_item.bl   = i_box_left;
        o_item.bu   = i_box_upper;
        o_item.br   = i_box_right;
        o_item.bd   = i_box_lower;
        o_item.oc   = i_out_col;
        o_item.orow = i_out_row;
    end

    assign o_in_stall = i_qstat.full;
    assign o_push     = i_in_valid && !i_qstat.full && w_known;
endmodule

/* rtl/core/smdu_queue.sv */
// Two-entry work queue between the front end and the executor.
// Depends on smdu_pkg.
module smdu_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  smdu_pkg::t_item  i_item,
    input  logic             i_pop,
    output smdu_pkg::t_item  o_head,
    output smdu_pkg::t_qstat o_qstat
);
    import smdu_pkg::*;

    t_item      r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_item;
        end
    end

    assign o_head        = r_slot[r_rp];
    assign o_qstat.full  = r_cnt == 2'd2;
    assign o_qstat.empty = r_cnt == 2'd0;
endmodule

/* rtl/core/smdu_back.sv */
// Executor: store writes, box mapping, nearest-neighbour divide and dot product.
// Depends on smdu_pkg; holds the prototype and coefficient memories.
module smdu_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  smdu_pkg::t_cfg   i_cfg,
    input  smdu_pkg::t_item  i_head,
    input  smdu_pkg::t_qstat i_qstat,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_mask_bit,
    output logic             o_mask_valid
);
    import smdu_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MAP_A, S_MAP_B, S_CHECK, S_DIV, S_BASE, S_MAC, S_DONE
    } t_state;

    t_state                  r_state;
    t_item                   r_item;
    logic [1:0]              r_k;
    logic [31:0]             r_prod1;
    logic [CRD_W-1:0]        r_crd [4];
    logic [17:0]             r_num;
    logic [BOX_W-1:0]        r_den;
    logic [CRD_W-1:0]        r_q;
    logic [2:0]              r_dstep;
    logic                    r_daxis;
    logic [CRD_W-1:0]        r_sx;
    logic [CELL_W-1:0]       r_cell;
    logic [CI_W:0]           r_cnt;
    logic                    r_rd_v;
    logic                    r_mul_v;
    logic signed [VAL_W-1:0] r_pv;
    logic signed [VAL_W-1:0] r_cv;
    logic signed [31:0]      r_mul;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_res_bit;
    logic                    r_res_mv;

    logic signed [VAL_W-1:0] r_pmem [PROTO_DEPTH];
    logic signed [VAL_W-1:0] r_cmem [NUM_COEFF];

    logic [BOX_W-1:0]  w_src;
    logic [19:0]       w_scale;
    logic [9:0]        w_pad;
    logic [16:0]       w_ratio;
    logic [SIZE_W-1:0] w_size;
    logic [31:0]       w_m1;
    logic [16:0]       w_model;
    logic [33:0]       w_m2;
    logic [17:0]       w_p;
    logic [CRD_W-1:0]  w_lim;
    logic [CRD_W-1:0]  w_crd;
    logic [BOX_W-1:0]  w_ow;
    logic [BOX_W-1:0]  w_oh;
    logic [CRD_W-1:0]  w_mw;
    logic [CRD_W-1:0]  w_mh;
    logic              w_bad;
    logic [17:0]       w_dsub;
    logic              w_hit;
    logic [CRD_W-1:0]  w_qn;
    logic [CRD_W-1:0]  w_row;
    logic [CRD_W-1:0]  w_col;
    logic              w_issue;
    logic [PA_W-1:0]   w_raddr;
    logic              w_out_free;

    always_comb begin
        case (r_k)
            2'd0:    w_src = r_item.bl;
            2'd1:    w_src = r_item.bu;
            2'd2:    w_src = r_item.br;
            default: w_src = r_item.bd;
        endcase
        w_scale = r_k[0] ? i_cfg.scale_y : i_cfg.scale_x;
        w_pad   = r_k[0] ? i_cfg.pad_t   : i_cfg.pad_l;
        w_ratio = r_k[0] ? i_cfg.ratio_y : i_cfg.ratio_x;
        w_size  = r_k[0] ? i_cfg.ph      : i_cfg.pw;
        w_m1    = 32'(w_src) * 32'(w_scale);
        w_model = 17'(r_prod1[31:16]) + 17'(w_pad);
        w_m2    = 34'(w_model) * 34'(w_ratio);
        w_p     = w_m2[33:16];
        w_lim   = CRD_W'(w_size - 7'd1);
        w_crd   = (w_p > 18'(w_lim)) ? w_lim : w_p[CRD_W-1:0];

        w_ow    = r_item.br - r_item.bl;
        w_oh    = r_item.bd - r_item.bu;
        w_mw    = r_crd[2] - r_crd[0];
        w_mh    = r_crd[3] - r_crd[1];
        w_bad   = (r_crd[2] <= r_crd[0]) || (r_crd[3] <= r_crd[1]) ||
                  (r_item.br <= r_item.bl) || (r_item.bd <= r_item.bu) ||
                  (r_item.oc >= w_ow) || (r_item.orow >= w_oh);

        w_dsub  = 18'(r_den) << r_dstep;
        w_hit   = r_num >= w_dsub;
        w_qn    = r_q | (CRD_W'(w_hit) << r_dstep);

        w_row   = r_crd[1] + w_qn;
        w_col   = r_crd[0] + r_sx;

        w_issue = (r_state == S_MAC) && (r_cnt < (CI_W+1)'(NUM_COEFF));
        w_raddr = PA_W'(r_cell * NUM_COEFF) + PA_W'(r_cnt[CI_W-1:0]);

        w_out_free = !o_out_valid || !i_out_stall;
    end

    assign o_pop = (r_state == S_IDLE) && !i_qstat.empty;

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.op == OP_PROTO) begin
            r_pmem[i_head.addr] <= i_head.value;
        end
        r_pv <= r_pmem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.op == OP_COEFF) begin
            r_cmem[i_head.cidx] <= i_head.value;
        end
        r_cv <= r_cmem[r_cnt[CI_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_v      <= 1'b0;
            r_mul_v     <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_rd_v  <= w_issue;
            r_mul_v <= r_rd_v;
            r_mul   <= r_pv * r_cv;
            if (r_state == S_DONE && w_out_free) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop && i_head.op == OP_QUERY) begin
                        r_item  <= i_head;
                        r_k     <= 2'd0;
                        r_state <= S_MAP_A;
                    end
                end
                S_MAP_A: begin
                    r_prod1 <= w_m1;
                    r_state <= S_MAP_B;
                end
                S_MAP_B: begin
                    r_crd[r_k] <= w_crd;
                    r_k        <= r_k + 2'd1;
                    r_state    <= (r_k == 2'd3) ? S_CHECK : S_MAP_A;
                end
                S_CHECK: begin
                    if (w_bad) begin
                        r_res_bit <= 1'b0;
                        r_res_mv  <= 1'b0;
                        r_state   <= S_DONE;
                    end else begin
                        r_num   <= 18'(r_item.oc) * 18'(w_mw);
                        r_den   <= w_ow;
                        r_q     <= '0;
                        r_dstep <= 3'(CRD_W - 1);
                        r_daxis <= 1'b0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_dstep != 3'd0) begin
                        r_q <= w_qn;
                        if (w_hit) begin
                            r_num <= r_num - w_dsub;
                        end
                        r_dstep <= r_dstep - 3'd1;
                    end else if (!r_daxis) begin
                        r_sx    <= w_qn;
                        r_num   <= 18'(r_item.orow) * 18'(w_mh);
                        r_den   <= w_oh;
                        r_q     <= '0;
                        r_dstep <= 3'(CRD_W - 1);
                        r_daxis <= 1'b1;
                    end else begin
                        r_cell  <= CELL_W'(w_row) * CELL_W'(i_cfg.pw) + CELL_W'(w_col);
                        r_state <= S_BASE;
                    end
                end
                S_BASE: begin
                    r_cnt   <= '0;
                    r_acc   <= '0;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    if (w_issue) begin
                        r_cnt <= r_cnt + (CI_W+1)'(1);
                    end
                    if (r_mul_v) begin
                        r_acc <= r_acc + ACC_W'(r_mul);
                    end
                    if (!w_issue && !r_rd_v && !r_mul_v) begin
                        r_res_bit <= r_acc > 0;
                        r_res_mv  <= 1'b1;
                        r_state   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        o_mask_bit   <= r_res_bit;
                        o_mask_valid <= r_res_mv;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* rtl/core/seg_mask_dot_upsample_core.sv */
// Top level of the instance mask dot product core: config registers and wiring.
// Depends on smdu_pkg, smdu_front, smdu_queue, smdu_back and the assertion header.
//
//  channel | handshake                   | payload
//  in      | i_in_valid / o_in_stall     | i_action .. i_out_row
//  out     | o_out_valid / i_out_stall   | o_mask_bit, o_mask_valid
//  cfg     | i_cfg_we                    | i_cfg_index, i_cfg_data
//
// Load beats write memory when popped; a query runs the box mapping, two 6-step
// divides and a 32-step multiply-accumulate over the prototype memory port.
// A two-entry queue lets the front accept while the executor works.
// Reset clears control state and presets config; memories undefined until written.
// Output stall holds the result register and the executor waits in its done state.
`include "seg_mask_dot_upsample_core_assert.svh"
module seg_mask_dot_upsample_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [smdu_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [smdu_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_action,
    input  logic [smdu_pkg::PA_W-1:0]          i_proto_addr,
    input  logic signed [15:0]                 i_proto_value,
    input  logic [smdu_pkg::CI_W-1:0]          i_coeff_index,
    input  logic signed [15:0]                 i_coeff_value,
    input  logic [11:0]                        i_box_left,
    input  logic [11:0]                        i_box_upper,
    input  logic [11:0]                        i_box_right,
    input  logic [11:0]                        i_box_lower,
    input  logic [11:0]                        i_out_col,
    input  logic [11:0]                        i_out_row,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_mask_bit,
    output logic                               o_mask_valid
);
    import smdu_pkg::*;

    t_cfg              r_cfg;
    t_item             w_item;
    t_item             w_head;
    t_qstat            w_qstat;
    logic              w_push;
    logic              w_pop;
    logic [SIZE_W-1:0] w_wsat;
    logic [SIZE_W-1:0] w_hsat;

    always_comb begin
        w_wsat = i_cfg_data[SIZE_W-1:0];
        if (w_wsat == '0) begin
            w_wsat = SIZE_W'(1);
        end else if (w_wsat > SIZE_W'(PROTO_MAX_W)) begin
            w_wsat = SIZE_W'(PROTO_MAX_W);
        end
        w_hsat = i_cfg_data[SIZE_W-1:0];
        if (w_hsat == '0) begin
            w_hsat = SIZE_W'(1);
        end else if (w_hsat > SIZE_W'(PROTO_MAX_H)) begin
            w_hsat = SIZE_W'(PROTO_MAX_H);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pw      <= 7'd40;
            r_cfg.ph      <= 7'd40;
            r_cfg.scale_x <= 20'd65536;
            r_cfg.scale_y <= 20'd65536;
            r_cfg.pad_l   <= 10'd0;
            r_cfg.pad_t   <= 10'd0;
            r_cfg.ratio_x <= 17'd16384;
            r_cfg.ratio_y <= 17'd16384;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PROTO_W: r_cfg.pw      <= w_wsat;
                CFG_PROTO_H: r_cfg.ph      <= w_hsat;
                CFG_SCALE_X: r_cfg.scale_x <= i_cfg_data;
                CFG_SCALE_Y: r_cfg.scale_y <= i_cfg_data;
                CFG_PAD_L:   r_cfg.pad_l   <= i_cfg_data[9:0];
                CFG_PAD_T:   r_cfg.pad_t   <= i_cfg_data[9:0];
                CFG_RATIO_X: r_cfg.ratio_x <= i_cfg_data[16:0];
                CFG_RATIO_Y: r_cfg.ratio_y <= i_cfg_data[16:0];
                default:     r_cfg.pw      <= r_cfg.pw;
            endcase
        end
    end

    smdu_front u_front (
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_proto_addr  (i_proto_addr),
        .i_proto_value (i_proto_value),
        .i_coeff_index (i_coeff_index),
        .i_coeff_value (i_coeff_value),
        .i_box_left    (i_box_left),
        .i_box_upper   (i_box_upper),
        .i_box_right   (i_box_right),
        .i_box_lower   (i_box_lower),
        .i_out_col     (i_out_col),
        .i_out_row     (i_out_row),
        .i_qstat       (w_qstat),
        .o_push        (w_push),
        .o_item        (w_item)
    );

    smdu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_qstat (w_qstat)
    );

    smdu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head       (w_head),
        .i_qstat      (w_qstat),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_mask_bit   (o_mask_bit),
        .o_mask_valid (o_mask_valid)
    );

    `SMDU_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, w_push, !w_qstat.full)
    `SMDU_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, w_pop, !w_qstat.empty)
    `SMDU_ASSERT_IMP(a_invalid_bit_low, i_clk, i_rst_n, o_out_valid && !o_mask_valid, !o_mask_bit)
endmodule
